[hdl/mhsic_pkg.sv]
`timescale 1ns / 1ps
// Shared types, widths and constants for the magnetometer calibrator.
// No dependencies; every other file refers to this package by scoped names.
package mhsic_pkg;

    localparam int GAIN_FRAC_BITS = 16;
    localparam int AXIS_COUNT     = 3;
    localparam int NUM_AXES       = 3;

    localparam int RAW_W  = 16;
    localparam int OFF_W  = 17;
    localparam int GAIN_W = 24;
    localparam int SPAN_W = 16;
    localparam int DIFF_W = 18;
    localparam int PROD_W = DIFF_W + GAIN_W + 1;
    localparam int SUM_W  = 18;
    localparam int DEN_W  = 18;
    localparam int NUM_W  = SUM_W + GAIN_FRAC_BITS;
    localparam int CNT_W  = $clog2(NUM_W + 1);
    localparam int AXIS_W = 2;

    localparam logic signed [RAW_W-1:0] RAW_MAX = 16'sh7FFF;
    localparam logic signed [RAW_W-1:0] RAW_MIN = -16'sh8000;
    localparam logic [GAIN_W-1:0] GAIN_ONE = GAIN_W'(1) << GAIN_FRAC_BITS;
    localparam logic [GAIN_W-1:0] GAIN_MAX = '1;
    localparam logic [AXIS_W-1:0] AXIS_LAST = AXIS_W'(AXIS_COUNT - 1);

    typedef enum logic [1:0] {
        KIND_CORRECT = 2'd0,
        KIND_START   = 2'd1,
        KIND_SAMPLE  = 2'd2,
        KIND_FINISH  = 2'd3
    } kind_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_TRACK,
        ST_MUL,
        ST_SAT,
        ST_SUM,
        ST_DIV_LOAD,
        ST_DIV_RUN,
        ST_DIV_STORE,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic              load;
        logic              clear;
        logic              track;
        logic              mul;
        logic              sat;
        logic              sum;
        logic              div_go;
        logic              store;
        logic [AXIS_W-1:0] axis;
    } cmd_t;

    typedef struct packed {
        logic sample_seen;
        logic span_zero;
        logic div_done;
    } stat_t;

endpackage

[hdl/magnetometer_hard_soft_iron_calibrator.sv]
`timescale 1ns / 1ps
// Top level of the min/max hard-iron and soft-iron magnetometer calibrator.
// Depends on mhsic_pkg, mhsic_ctrl, mhsic_dp (and mhsic_div below it).
//
//  channel  | handshake               | payload
//  ---------+-------------------------+---------------------------------------
//  request  | start in, busy out      | kind, raw_x, raw_y, raw_z
//  result   | done out (1-cycle pulse)| corr_*, offset_*2, gain_*
//
// A request is taken on a clock edge with start high and busy low; busy then
// stays high until the result has gone out. Start passes through the clear state
// and a calibration sample through the track state before the done pulse; a
// finish with no sample seen goes straight to the done state.
// Correct runs each axis in turn through the single 18x25 multiplier, which is
// shared: a multiply state, then a shift-and-saturate state, per axis.
// Finish sums the spans, then runs the restoring divider on each axis in turn,
// which yields one gain quotient bit per cycle; an axis with zero span does not
// wait for its division and takes unity gain. busy drops the cycle after done.
// rst_n resets the trackers, offsets and gains (gains to unity) asynchronously.
// The receiver cannot stall: each result is valid for the done cycle only.
module magnetometer_hard_soft_iron_calibrator (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  logic [1:0]                           kind,
    input  logic signed [mhsic_pkg::RAW_W-1:0]   raw_x,
    input  logic signed [mhsic_pkg::RAW_W-1:0]   raw_y,
    input  logic signed [mhsic_pkg::RAW_W-1:0]   raw_z,
    output logic                                 done,
    output logic signed [mhsic_pkg::RAW_W-1:0]   corr_x,
    output logic signed [mhsic_pkg::RAW_W-1:0]   corr_y,
    output logic signed [mhsic_pkg::RAW_W-1:0]   corr_z,
    output logic signed [mhsic_pkg::OFF_W-1:0]   offset_x2,
    output logic signed [mhsic_pkg::OFF_W-1:0]   offset_y2,
    output logic signed [mhsic_pkg::OFF_W-1:0]   offset_z2,
    output logic [mhsic_pkg::GAIN_W-1:0]         gain_x,
    output logic [mhsic_pkg::GAIN_W-1:0]         gain_y,
    output logic [mhsic_pkg::GAIN_W-1:0]         gain_z
);

    mhsic_pkg::cmd_t  cmd;
    mhsic_pkg::stat_t stat;

    // Controller: decodes the request kind and walks the axes.
    mhsic_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .kind  (kind),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (busy),
        .done  (done)
    );

    // Datapath: hold the trackers and calibration, drive the result ports.
    mhsic_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .stat      (stat),
        .raw_x     (raw_x),
        .raw_y     (raw_y),
        .raw_z     (raw_z),
        .corr_x    (corr_x),
        .corr_y    (corr_y),
        .corr_z    (corr_z),
        .offset_x2 (offset_x2),
        .offset_y2 (offset_y2),
        .offset_z2 (offset_z2),
        .gain_x    (gain_x),
        .gain_y    (gain_y),
        .gain_z    (gain_z)
    );

    // An accepted request must make the block busy on the next cycle.
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted request did not raise busy");

    // After a result the block returns to idle.
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !busy)
        else $error("block still busy after result");

    // A result only leaves while a request is in progress.
    a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> busy)
        else $error("result without a request in progress");

    // Gains never reach zero: the span sum is at least the axis span.
    a_gain_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (gain_x != '0) && (gain_y != '0) && (gain_z != '0))
        else $error("zero gain reported");

endmodule

[hdl/mhsic_div.sv]
`timescale 1ns / 1ps
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on mhsic_pkg for widths.
module mhsic_div (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          go,
    input  logic [mhsic_pkg::NUM_W-1:0]   dividend,
    input  logic [mhsic_pkg::DEN_W-1:0]   divisor,
    output logic                          done,
    output logic [mhsic_pkg::NUM_W-1:0]   quotient
);

    logic [mhsic_pkg::DEN_W-1:0] rem_reg;
    logic [mhsic_pkg::NUM_W-1:0] quo_reg;
    logic [mhsic_pkg::DEN_W-1:0] den_reg;
    logic [mhsic_pkg::CNT_W-1:0] cnt_reg;
    logic                        run_reg;
    logic                        done_reg;

    logic [mhsic_pkg::DEN_W:0]   rem_shift;
    logic                        fits;

    always_comb
    begin
        rem_shift = {rem_reg, quo_reg[mhsic_pkg::NUM_W-1]};
        fits      = rem_shift >= {1'b0, den_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (go)
            begin
                run_reg <= 1'b1;
                cnt_reg <= mhsic_pkg::CNT_W'(mhsic_pkg::NUM_W);
            end
            else if (run_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == mhsic_pkg::CNT_W'(1))
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (go)
        begin
            rem_reg <= '0;
            quo_reg <= dividend;
            den_reg <= divisor;
        end
        else if (run_reg)
        begin
            // shift in one dividend bit, subtract where it fits
            if (fits)
                rem_reg <= mhsic_pkg::DEN_W'(rem_shift - {1'b0, den_reg});
            else
                rem_reg <= rem_shift[mhsic_pkg::DEN_W-1:0];
            quo_reg <= {quo_reg[mhsic_pkg::NUM_W-2:0], fits};
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

[hdl/mhsic_dp.sv]
`timescale 1ns / 1ps
// Calibrator datapath: trackers, offsets, gains, shared multiplier and divider.
// Depends on mhsic_pkg and mhsic_div; driven by commands from mhsic_ctrl.
module mhsic_dp (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  mhsic_pkg::cmd_t                      cmd,
    output mhsic_pkg::stat_t                     stat,
    input  logic signed [mhsic_pkg::RAW_W-1:0]   raw_x,
    input  logic signed [mhsic_pkg::RAW_W-1:0]   raw_y,
    input  logic signed [mhsic_pkg::RAW_W-1:0]   raw_z,
    output logic signed [mhsic_pkg::RAW_W-1:0]   corr_x,
    output logic signed [mhsic_pkg::RAW_W-1:0]   corr_y,
    output logic signed [mhsic_pkg::RAW_W-1:0]   corr_z,
    output logic signed [mhsic_pkg::OFF_W-1:0]   offset_x2,
    output logic signed [mhsic_pkg::OFF_W-1:0]   offset_y2,
    output logic signed [mhsic_pkg::OFF_W-1:0]   offset_z2,
    output logic [mhsic_pkg::GAIN_W-1:0]         gain_x,
    output logic [mhsic_pkg::GAIN_W-1:0]         gain_y,
    output logic [mhsic_pkg::GAIN_W-1:0]         gain_z
);

    localparam int SHIFT = mhsic_pkg::GAIN_FRAC_BITS + 1;
    localparam logic signed [mhsic_pkg::PROD_W-1:0] RND_BIAS =
        (mhsic_pkg::PROD_W'(1) <<< SHIFT) - mhsic_pkg::PROD_W'(1);

    logic signed [mhsic_pkg::RAW_W-1:0]  raw_reg  [mhsic_pkg::NUM_AXES];
    logic signed [mhsic_pkg::RAW_W-1:0]  corr_reg [mhsic_pkg::NUM_AXES];
    logic signed [mhsic_pkg::RAW_W-1:0]  min_reg  [mhsic_pkg::NUM_AXES];
    logic signed [mhsic_pkg::RAW_W-1:0]  max_reg  [mhsic_pkg::NUM_AXES];
    logic signed [mhsic_pkg::OFF_W-1:0]  off2_reg [mhsic_pkg::NUM_AXES];
    logic [mhsic_pkg::GAIN_W-1:0]        gain_reg [mhsic_pkg::NUM_AXES];
    logic                                seen_reg;
    logic signed [mhsic_pkg::PROD_W-1:0] prod_reg;
    logic [mhsic_pkg::SUM_W-1:0]         sum_reg;

    logic signed [mhsic_pkg::PROD_W-1:0] prod_next;
    logic [mhsic_pkg::SUM_W-1:0]         sum_next;
    logic signed [mhsic_pkg::DIFF_W-1:0] diff;
    logic signed [mhsic_pkg::GAIN_W:0]   gain_s;
    logic signed [mhsic_pkg::PROD_W-1:0] prod_adj;
    logic signed [mhsic_pkg::PROD_W-1:0] quot;
    logic signed [mhsic_pkg::RAW_W-1:0]  corr_sat;
    logic signed [mhsic_pkg::OFF_W:0]    span_full;
    logic [mhsic_pkg::SPAN_W-1:0]        span;
    logic [mhsic_pkg::DEN_W-1:0]         divisor;
    logic [mhsic_pkg::NUM_W-1:0]         dividend;
    logic [mhsic_pkg::NUM_W-1:0]         quotient;
    logic                                div_done;
    logic [mhsic_pkg::GAIN_W-1:0]        gain_new;

    // correction: one axis through the multiplier, then shift and saturate
    always_comb
    begin
        diff = (mhsic_pkg::DIFF_W'(raw_reg[cmd.axis]) <<< 1)
             - mhsic_pkg::DIFF_W'(off2_reg[cmd.axis]);
        gain_s    = $signed({1'b0, gain_reg[cmd.axis]});
        prod_next = mhsic_pkg::PROD_W'(diff) * mhsic_pkg::PROD_W'(gain_s);

        // bias negatives so the shift truncates toward zero
        prod_adj = prod_reg + (prod_reg[mhsic_pkg::PROD_W-1] ? RND_BIAS : '0);
        quot     = prod_adj >>> SHIFT;
        if (quot > mhsic_pkg::PROD_W'(mhsic_pkg::RAW_MAX))
            corr_sat = mhsic_pkg::RAW_MAX;
        else if (quot < mhsic_pkg::PROD_W'(mhsic_pkg::RAW_MIN))
            corr_sat = mhsic_pkg::RAW_MIN;
        else
            corr_sat = quot[mhsic_pkg::RAW_W-1:0];
    end

    // finish: spans, their sum and the gain quotient
    always_comb
    begin
        span_full = mhsic_pkg::OFF_W'(max_reg[cmd.axis]) + 18'sd0
                  - (mhsic_pkg::OFF_W'(min_reg[cmd.axis]) + 18'sd0);
        span      = span_full[mhsic_pkg::SPAN_W-1:0];
        divisor   = mhsic_pkg::DEN_W'(span) * mhsic_pkg::DEN_W'(mhsic_pkg::AXIS_COUNT);
        dividend  = {sum_reg, mhsic_pkg::GAIN_FRAC_BITS'(0)};

        // spans are unsigned: zero-extend them into the sum
        sum_next = '0;
        for (int a = 0; a < mhsic_pkg::NUM_AXES; a++)
        begin
            if (a < mhsic_pkg::AXIS_COUNT)
                sum_next = sum_next + mhsic_pkg::SUM_W'($unsigned(
                    mhsic_pkg::SPAN_W'(max_reg[a] - min_reg[a])));
        end

        if (span == '0)
            gain_new = mhsic_pkg::GAIN_ONE;
        else if (|quotient[mhsic_pkg::NUM_W-1:mhsic_pkg::GAIN_W])
            gain_new = mhsic_pkg::GAIN_MAX;
        else
            gain_new = quotient[mhsic_pkg::GAIN_W-1:0];
    end

    mhsic_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .go       (cmd.div_go),
        .dividend (dividend),
        .divisor  (divisor),
        .done     (div_done),
        .quotient (quotient)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_reg <= 1'b0;
            for (int a = 0; a < mhsic_pkg::NUM_AXES; a++)
            begin
                min_reg[a]  <= mhsic_pkg::RAW_MAX;
                max_reg[a]  <= mhsic_pkg::RAW_MIN;
                off2_reg[a] <= '0;
                gain_reg[a] <= mhsic_pkg::GAIN_ONE;
            end
        end
        else
        begin
            if (cmd.clear)
            begin
                seen_reg <= 1'b0;
                for (int a = 0; a < mhsic_pkg::NUM_AXES; a++)
                begin
                    min_reg[a] <= mhsic_pkg::RAW_MAX;
                    max_reg[a] <= mhsic_pkg::RAW_MIN;
                end
            end
            if (cmd.track)
            begin
                seen_reg <= 1'b1;
                for (int a = 0; a < mhsic_pkg::NUM_AXES; a++)
                begin
                    if (a < mhsic_pkg::AXIS_COUNT)
                    begin
                        if (raw_reg[a] < min_reg[a])
                            min_reg[a] <= raw_reg[a];
                        if (raw_reg[a] > max_reg[a])
                            max_reg[a] <= raw_reg[a];
                    end
                end
            end
            if (cmd.store)
            begin
                off2_reg[cmd.axis] <= mhsic_pkg::OFF_W'(max_reg[cmd.axis])
                                    + mhsic_pkg::OFF_W'(min_reg[cmd.axis]);
                gain_reg[cmd.axis] <= gain_new;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            raw_reg[0] <= raw_x;
            raw_reg[1] <= raw_y;
            raw_reg[2] <= raw_z;
            for (int a = 0; a < mhsic_pkg::NUM_AXES; a++)
                corr_reg[a] <= '0;
        end
        if (cmd.mul)
            prod_reg <= prod_next;
        if (cmd.sat)
            corr_reg[cmd.axis] <= corr_sat;
        if (cmd.sum)
            sum_reg <= sum_next;
    end

    assign stat.sample_seen = seen_reg;
    assign stat.span_zero   = (span == '0);
    assign stat.div_done    = div_done;

    assign corr_x    = corr_reg[0];
    assign corr_y    = corr_reg[1];
    assign corr_z    = corr_reg[2];
    assign offset_x2 = off2_reg[0];
    assign offset_y2 = off2_reg[1];
    assign offset_z2 = off2_reg[2];
    assign gain_x    = gain_reg[0];
    assign gain_y    = gain_reg[1];
    assign gain_z    = gain_reg[2];

endmodule

[hdl/mhsic_ctrl.sv]
`timescale 1ns / 1ps
// Calibrator controller: sequences the datapath per request kind and axis.
// Depends on mhsic_pkg for the state, kind, command and status types.
module mhsic_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [1:0]       kind,
    input  mhsic_pkg::stat_t stat,
    output mhsic_pkg::cmd_t  cmd,
    output logic             busy,
    output logic             done
);

    mhsic_pkg::state_t                state_reg, state_next;
    logic [mhsic_pkg::AXIS_W-1:0]     axis_reg, axis_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= mhsic_pkg::ST_IDLE;
            axis_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            axis_reg  <= axis_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        axis_next  = axis_reg;
        unique case (state_reg)
            mhsic_pkg::ST_IDLE:
            begin
                axis_next = '0;
                if (start)
                begin
                    unique case (mhsic_pkg::kind_t'(kind))
                        mhsic_pkg::KIND_CORRECT: state_next = mhsic_pkg::ST_MUL;
                        mhsic_pkg::KIND_START:   state_next = mhsic_pkg::ST_CLEAR;
                        mhsic_pkg::KIND_SAMPLE:  state_next = mhsic_pkg::ST_TRACK;
                        mhsic_pkg::KIND_FINISH:
                            state_next = stat.sample_seen ? mhsic_pkg::ST_SUM
                                                          : mhsic_pkg::ST_DONE;
                        default:                 state_next = mhsic_pkg::ST_DONE;
                    endcase
                end
            end
            mhsic_pkg::ST_CLEAR:    state_next = mhsic_pkg::ST_DONE;
            mhsic_pkg::ST_TRACK:    state_next = mhsic_pkg::ST_DONE;
            mhsic_pkg::ST_MUL:      state_next = mhsic_pkg::ST_SAT;
            mhsic_pkg::ST_SAT:
            begin
                if (axis_reg == mhsic_pkg::AXIS_LAST)
                    state_next = mhsic_pkg::ST_DONE;
                else
                begin
                    state_next = mhsic_pkg::ST_MUL;
                    axis_next  = axis_reg + 1'b1;
                end
            end
            mhsic_pkg::ST_SUM:      state_next = mhsic_pkg::ST_DIV_LOAD;
            mhsic_pkg::ST_DIV_LOAD:
                state_next = stat.span_zero ? mhsic_pkg::ST_DIV_STORE
                                            : mhsic_pkg::ST_DIV_RUN;
            mhsic_pkg::ST_DIV_RUN:
            begin
                if (stat.div_done)
                    state_next = mhsic_pkg::ST_DIV_STORE;
            end
            mhsic_pkg::ST_DIV_STORE:
            begin
                if (axis_reg == mhsic_pkg::AXIS_LAST)
                    state_next = mhsic_pkg::ST_DONE;
                else
                begin
                    state_next = mhsic_pkg::ST_DIV_LOAD;
                    axis_next  = axis_reg + 1'b1;
                end
            end
            mhsic_pkg::ST_DONE:     state_next = mhsic_pkg::ST_IDLE;
            default:                state_next = mhsic_pkg::ST_IDLE;
        endcase
    end

    // outputs; the divider is always launched, a zero-span axis drops its quotient
    always_comb
    begin
        cmd        = '0;
        cmd.axis   = axis_reg;
        cmd.load   = (state_reg == mhsic_pkg::ST_IDLE) && start;
        cmd.clear  = (state_reg == mhsic_pkg::ST_CLEAR);
        cmd.track  = (state_reg == mhsic_pkg::ST_TRACK);
        cmd.mul    = (state_reg == mhsic_pkg::ST_MUL);
        cmd.sat    = (state_reg == mhsic_pkg::ST_SAT);
        cmd.sum    = (state_reg == mhsic_pkg::ST_SUM);
        cmd.div_go = (state_reg == mhsic_pkg::ST_DIV_LOAD);
        cmd.store  = (state_reg == mhsic_pkg::ST_DIV_STORE);
        busy       = (state_reg != mhsic_pkg::ST_IDLE);
        done       = (state_reg == mhsic_pkg::ST_DONE);
    end

endmodule
